// File: rtl/core/hidkm_pkg.sv
// Shared types and constants of the keyboard report to mouse button block.
package hidkm_pkg;

	// Field widths of the input report and of one event.
	localparam int LEN_W = 7;
	localparam int MOD_W = 8;
	localparam int KEY_W = 8;
	localparam int BTN_W = 3;
	localparam int INPUT_SLOTS = 6;

	// Stream widths; tdata is padded to whole bytes.
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 1;

	// Input tdata layout, lowest bit first.
	localparam int IN_LEN_LSB = 0;
	localparam int IN_MOD_LSB = IN_LEN_LSB + LEN_W;
	localparam int IN_SLOT_LSB = IN_MOD_LSB + MOD_W;

	// Output tdata layout, lowest bit first.
	localparam int OUT_KEY_LSB = 0;
	localparam int OUT_MOD_LSB = OUT_KEY_LSB + KEY_W;
	localparam int OUT_SEND_LSB = OUT_MOD_LSB + MOD_W;
	localparam int OUT_BTN_LSB = OUT_SEND_LSB + 1;
	localparam int OUT_USED_W = OUT_BTN_LSB + BTN_W;

	// Report rules.
	localparam logic [LEN_W-1:0] MIN_REPORT_LEN = 7'd8;
	localparam logic [KEY_W-1:0] FIRST_EVENT_CODE = 8'd4;
	localparam logic [KEY_W-1:0] KEY_CODE_FIRST = 8'd4;
	localparam logic [KEY_W-1:0] KEY_CODE_SECOND = 8'd5;
	localparam logic [KEY_W-1:0] KEY_CODE_THIRD = 8'd6;
	localparam int LEFT_SHIFT_BIT = 1;
	localparam int RIGHT_SHIFT_BIT = 5;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = BTN_W;
	localparam logic [CFG_INDEX_W-1:0] CFG_BTN_FIRST = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BTN_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BTN_THIRD = 2'd2;

	// Reset values of the button registers.
	localparam logic [BTN_W-1:0] BTN_FIRST_RST = 3'd1;
	localparam logic [BTN_W-1:0] BTN_SECOND_RST = 3'd4;
	localparam logic [BTN_W-1:0] BTN_THIRD_RST = 3'd2;

	// Entries in the queue between front and back end.
	localparam int QUEUE_DEPTH = 2;

	// Button values programmed for the three mapped keys.
	typedef struct packed {
		logic [BTN_W-1:0] first;
		logic [BTN_W-1:0] second;
		logic [BTN_W-1:0] third;
	} btn_cfg_t;

endpackage

// File: rtl/core/hidkm_front.sv
// Front end: takes reports, diffs them against the held keys and queues event masks.
module hidkm_front import hidkm_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	parameter int ENTRY_W = MOD_W + 2 * KEY_SLOTS * KEY_W + 2 * KEY_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IN_TDATA_W-1:0] in_data,
	input  logic                  queue_full,
	output logic                  push,
	output logic [ENTRY_W-1:0]    push_entry
);

	localparam int EV_W = 2 * KEY_SLOTS;

	logic [KEY_W-1:0] prev_q [KEY_SLOTS];
	logic [KEY_W-1:0] cur [KEY_SLOTS];
	logic [LEN_W-1:0] len;
	logic [MOD_W-1:0] mod;
	logic             long_report;
	logic             accept;
	logic [KEY_SLOTS-1:0] old_kept;
	logic [KEY_SLOTS-1:0] new_seen;
	logic [EV_W-1:0]       mask;
	logic [EV_W*KEY_W-1:0] ev_keys;

	assign len = in_data[IN_LEN_LSB +: LEN_W];
	assign mod = in_data[IN_MOD_LSB +: MOD_W];

	// Current slots; slots beyond the report read as empty.
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cur
		if (g < INPUT_SLOTS) begin : g_in
			assign cur[g] = in_data[IN_SLOT_LSB + g * KEY_W +: KEY_W];
		end else begin : g_zero
			assign cur[g] = '0;
		end
	end

	// Presence checks in both directions, all slot pairs side by side.
	always_comb begin
		old_kept = '0;
		new_seen = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (cur[j] == prev_q[i]) begin
					old_kept[i] = 1'b1;
				end
				if (prev_q[j] == cur[i]) begin
					new_seen[i] = 1'b1;
				end
			end
		end
	end

	// Event mask in emission order: release of slot i, then press of slot i.
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			mask[2 * i]     = (prev_q[i] >= FIRST_EVENT_CODE) && !old_kept[i];
			mask[2 * i + 1] = (cur[i] >= FIRST_EVENT_CODE) && !new_seen[i];
			ev_keys[(2 * i) * KEY_W +: KEY_W]     = prev_q[i];
			ev_keys[(2 * i + 1) * KEY_W +: KEY_W] = cur[i];
		end
	end

	assign long_report = (len >= MIN_REPORT_LEN);
	assign in_ready    = !queue_full;
	assign accept      = in_valid && in_ready;
	assign push        = accept && long_report && (mask != '0);
	assign push_entry  = {mod, ev_keys, mask};

	// Held keys follow every full-length report, with or without events.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (accept && long_report) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= cur[i];
			end
		end
	end

`ifndef ASSERT_OFF
	a_push_has_events: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry[EV_W-1:0] != '0) && (len >= MIN_REPORT_LEN))
		else $error("queued report without events or too short");
`endif

endmodule

// File: rtl/core/hidkm_fifo.sv
// Short register queue between the front and back end.
module hidkm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/core/hidkm_back.sv
// Back end: walks the queued event mask and emits one event per transfer.
module hidkm_back import hidkm_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	parameter int ENTRY_W = MOD_W + 2 * KEY_SLOTS * KEY_W + 2 * KEY_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  btn_cfg_t           btn_cfg,
	input  logic               queue_empty,
	input  logic [ENTRY_W-1:0] queue_entry,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_press,
	output logic [KEY_W-1:0]   out_key,
	output logic [MOD_W-1:0]   out_mod,
	output logic               out_send,
	output logic [BTN_W-1:0]   out_btn,
	output logic               out_last
);

	localparam int EV_W = 2 * KEY_SLOTS;
	localparam int SEL_W = $clog2(EV_W);
	localparam int KEYS_W = EV_W * KEY_W;

	logic                  work_valid_q;
	logic [EV_W-1:0]       mask_q;
	logic [KEYS_W-1:0]     keys_q;
	logic [MOD_W-1:0]      mod_q;
	logic                  out_valid_q;
	logic                  out_press_q;
	logic [KEY_W-1:0]      out_key_q;
	logic [MOD_W-1:0]      out_mod_q;
	logic                  out_send_q;
	logic [BTN_W-1:0]      out_btn_q;
	logic                  out_last_q;
	logic [SEL_W-1:0]      sel;
	logic [EV_W-1:0]       rest;
	logic                  out_free;
	logic                  emit;
	logic                  emit_last;
	logic                  ev_press;
	logic [KEY_W-1:0]      ev_key;
	logic                  shifted;
	logic                  ev_send;
	logic [BTN_W-1:0]      ev_btn;

	// Lowest pending event goes first.
	always_comb begin
		sel = '0;
		for (int j = EV_W - 1; j >= 0; j--) begin
			if (mask_q[j]) begin
				sel = SEL_W'(j);
			end
		end
	end

	always_comb begin
		rest = mask_q;
		rest[sel] = 1'b0;
	end

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = work_valid_q && out_free;
	assign emit_last = emit && (rest == '0);
	assign pop       = !queue_empty && (!work_valid_q || emit_last);

	// Event contents: releases always send a zero button report.
	assign ev_press = sel[0];
	assign ev_key   = keys_q[sel * KEY_W +: KEY_W];
	assign shifted  = mod_q[LEFT_SHIFT_BIT] || mod_q[RIGHT_SHIFT_BIT];

	always_comb begin
		ev_send = 1'b1;
		ev_btn  = '0;
		if (ev_press) begin
			ev_send = 1'b0;
			if (!shifted) begin
				unique case (ev_key)
					KEY_CODE_FIRST: begin
						ev_send = 1'b1;
						ev_btn  = btn_cfg.first;
					end
					KEY_CODE_SECOND: begin
						ev_send = 1'b1;
						ev_btn  = btn_cfg.second;
					end
					KEY_CODE_THIRD: begin
						ev_send = 1'b1;
						ev_btn  = btn_cfg.third;
					end
					default: ;
				endcase
			end
		end
	end

	// Working report: loaded from the queue, drained one event at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
		end else if (pop) begin
			work_valid_q <= 1'b1;
		end else if (emit_last) begin
			work_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q <= queue_entry[EV_W-1:0];
			keys_q <= queue_entry[EV_W +: KEYS_W];
			mod_q  <= queue_entry[ENTRY_W-1 -: MOD_W];
		end else if (emit) begin
			mask_q <= rest;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_press_q <= ev_press;
			out_key_q   <= ev_key;
			out_mod_q   <= ev_press ? mod_q : '0;
			out_send_q  <= ev_send;
			out_btn_q   <= ev_btn;
			out_last_q  <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_press = out_press_q;
	assign out_key   = out_key_q;
	assign out_mod   = out_mod_q;
	assign out_send  = out_send_q;
	assign out_btn   = out_btn_q;
	assign out_last  = out_last_q;

`ifndef ASSERT_OFF
	a_work_pending: assert property (@(posedge clk) disable iff (!arst_n)
		work_valid_q |-> (mask_q != '0))
		else $error("working report holds no pending event");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_last && !pop) |=> !work_valid_q)
		else $error("working report kept after its final event");

	a_release_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !ev_press) |-> (ev_send && (ev_btn == '0)))
		else $error("release event with nonzero buttons");
`endif

endmodule

// File: rtl/core/hid_key_report_to_mouse_buttons_core.sv
// Top level of the keyboard report to mouse button block.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: report_length, modifier_bits, key_slot_0..5
//   m_axis    out        tdata: event_key, event_modifier, mouse_send, mouse_buttons;
//                        tuser: is_press; tlast: last_event
//   cfg       in         cfg_index selects a button register, cfg_data its value
//
// The front end takes one report per cycle while the queue has room.
// The back end emits one event per cycle while the output is ready; a report with n events
// (up to 2 * KEY_SLOTS, twelve by default) is walked event by event; that walk sets the rate.
// Reset clears the held keys, empties the queue and loads button values 1, 4 and 2.
// An output stall holds the event register; the queue then fills and stalls input.
module hid_key_report_to_mouse_buttons_core import hidkm_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// report_length [6:0], modifier_bits [14:7], key_slot_0..5 [22:15] .. [62:55]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// event_key [7:0], event_modifier [15:8], mouse_send [16], mouse_buttons [19:17]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// is_press [0]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ENTRY_W = MOD_W + 2 * KEY_SLOTS * KEY_W + 2 * KEY_SLOTS;

	btn_cfg_t           btn_cfg_q;
	logic               queue_full;
	logic               queue_empty;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_entry;
	logic [ENTRY_W-1:0] pop_entry;
	logic               ev_press;
	logic [KEY_W-1:0]   ev_key;
	logic [MOD_W-1:0]   ev_mod;
	logic               ev_send;
	logic [BTN_W-1:0]   ev_btn;

	// Button registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_cfg_q.first  <= BTN_FIRST_RST;
			btn_cfg_q.second <= BTN_SECOND_RST;
			btn_cfg_q.third  <= BTN_THIRD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BTN_FIRST:  btn_cfg_q.first  <= cfg_data;
				CFG_BTN_SECOND: btn_cfg_q.second <= cfg_data;
				CFG_BTN_THIRD:  btn_cfg_q.third  <= cfg_data;
				default: ;
			endcase
		end
	end

	hidkm_front #(
		.KEY_SLOTS (KEY_SLOTS),
		.ENTRY_W   (ENTRY_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	hidkm_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.pop_data  (pop_entry),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	hidkm_back #(
		.KEY_SLOTS (KEY_SLOTS),
		.ENTRY_W   (ENTRY_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.btn_cfg     (btn_cfg_q),
		.queue_empty (queue_empty),
		.queue_entry (pop_entry),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_press   (ev_press),
		.out_key     (ev_key),
		.out_mod     (ev_mod),
		.out_send    (ev_send),
		.out_btn     (ev_btn),
		.out_last    (m_axis_tlast)
	);

	// Pack the event onto the output stream.
	assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, ev_btn, ev_send, ev_mod, ev_key};
	assign m_axis_tuser = ev_press;

endmodule

// File: tb/hid_key_report_to_mouse_buttons_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the keyboard report to mouse button block.
module hid_key_report_to_mouse_buttons_core_test;
	import hidkm_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 53;
	localparam int HOLD_AT = 100;
	localparam int HOLD_CYCLES = 200;

	// One keyboard report as it sits on the input tdata, lowest field in the lowest bits.
	typedef struct packed {
		logic                              pad;
		logic [INPUT_SLOTS-1:0][KEY_W-1:0] keys;
		logic [MOD_W-1:0]                  mods;
		logic [LEN_W-1:0]                  len;
	} key_report_t;

	// One key event as the block should emit it.
	typedef struct {
		logic             is_press;
		logic [KEY_W-1:0] key;
		logic [MOD_W-1:0] mods;
		logic             send;
		logic [BTN_W-1:0] buttons;
		logic             last;
	} expected_event_t;

	typedef enum { BY_PREDICTOR, NO_EVENTS, ONE_EVENT } check_kind_t;

	typedef struct {
		key_report_t     report;
		check_kind_t     kind;
		expected_event_t typed;
	} table_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_BTN_FIRST;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Predictor state: keys of the last full report and the button settings.
	logic [INPUT_SLOTS-1:0][KEY_W-1:0] held_keys = '0;
	logic [BTN_W-1:0] btn_first = BTN_FIRST_RST;
	logic [BTN_W-1:0] btn_second = BTN_SECOND_RST;
	logic [BTN_W-1:0] btn_third = BTN_THIRD_RST;

	// Keys of the last full report offered, so random reports can keep keys held.
	logic [INPUT_SLOTS-1:0][KEY_W-1:0] recent_keys = '0;

	expected_event_t pending_events[$];
	int mismatches = 0;
	int events_seen = 0;
	bit calm = 1'b0;

	hid_key_report_to_mouse_buttons_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic key_report_t make_report(input logic [LEN_W-1:0] len,
			input logic [MOD_W-1:0] mods, input logic [KEY_W-1:0] k0, k1, k2, k3, k4, k5);
		key_report_t r;
		r.pad = 1'b0;
		r.len = len;
		r.mods = mods;
		r.keys = {k5, k4, k3, k2, k1, k0};
		return r;
	endfunction

	function automatic logic key_held(input logic [INPUT_SLOTS-1:0][KEY_W-1:0] set,
			input logic [KEY_W-1:0] code);
		for (int i = 0; i < INPUT_SLOTS; i++) begin
			if (set[i] == code) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Walk the slots in order: release of a vanished old key, then press of a new one.
	function automatic void diff_report(input key_report_t r, ref expected_event_t evs[$]);
		logic shifted;
		logic [KEY_W-1:0] old_key;
		logic [KEY_W-1:0] new_key;
		expected_event_t ev;
		evs.delete();
		if (r.len < MIN_REPORT_LEN) begin
			return;
		end
		shifted = r.mods[LEFT_SHIFT_BIT] | r.mods[RIGHT_SHIFT_BIT];
		for (int i = 0; i < INPUT_SLOTS; i++) begin
			old_key = held_keys[i];
			new_key = r.keys[i];
			if (old_key >= FIRST_EVENT_CODE && !key_held(r.keys, old_key)) begin
				ev = '{1'b0, old_key, 8'h00, 1'b1, 3'd0, 1'b0};
				evs.push_back(ev);
			end
			if (new_key >= FIRST_EVENT_CODE && !key_held(held_keys, new_key)) begin
				ev = '{1'b1, new_key, r.mods, 1'b0, 3'd0, 1'b0};
				if (!shifted) begin
					if (new_key == KEY_CODE_FIRST) begin
						ev.send = 1'b1;
						ev.buttons = btn_first;
					end else if (new_key == KEY_CODE_SECOND) begin
						ev.send = 1'b1;
						ev.buttons = btn_second;
					end else if (new_key == KEY_CODE_THIRD) begin
						ev.send = 1'b1;
						ev.buttons = btn_third;
					end
				end
				evs.push_back(ev);
			end
		end
		held_keys = r.keys;
		if (evs.size() != 0) begin
			evs[evs.size() - 1].last = 1'b1;
		end
	endfunction

	// Mostly well-formed reports that keep some keys held, with short reports and noise.
	function automatic key_report_t random_report();
		key_report_t r;
		int roll;
		r.pad = 1'b0;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			r.len = LEN_W'($urandom_range(0, 7));
		end else if (roll < 60) begin
			r.len = MIN_REPORT_LEN;
		end else begin
			r.len = LEN_W'($urandom_range(9, 64));
		end
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			r.mods = '0;
		end else if (roll < 85) begin
			r.mods = (roll % 2) ? (8'b1 << LEFT_SHIFT_BIT) : (8'b1 << RIGHT_SHIFT_BIT);
		end else begin
			r.mods = MOD_W'($urandom_range(0, 255));
		end
		for (int i = 0; i < INPUT_SLOTS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				r.keys[i] = recent_keys[i];
			end else if (roll < 60) begin
				r.keys[i] = '0;
			end else if (roll < 90) begin
				r.keys[i] = KEY_W'($urandom_range(1, 9));
			end else begin
				r.keys[i] = KEY_W'($urandom_range(0, 255));
			end
		end
		if (r.len >= MIN_REPORT_LEN) begin
			recent_keys = r.keys;
		end
		return r;
	endfunction

	// Queue the expected events of one report, then offer it until the transfer happens.
	task automatic send_report(input key_report_t r, input check_kind_t kind,
			input expected_event_t typed);
		expected_event_t evs[$];
		diff_report(r, evs);
		unique case (kind)
			BY_PREDICTOR: begin
				foreach (evs[i]) begin
					pending_events.push_back(evs[i]);
				end
			end
			ONE_EVENT: begin
				pending_events.push_back(typed);
			end
			default: begin
			end
		endcase
		if (!calm) begin
			while ($urandom_range(0, 99) < 10) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= r;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering, wait for every expected event, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_buttons(input logic [BTN_W-1:0] first, second, third);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BTN_FIRST;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_BTN_SECOND;
		cfg_data <= second;
		@(posedge clk);
		cfg_index <= CFG_BTN_THIRD;
		cfg_data <= third;
		@(posedge clk);
		cfg_we <= 1'b0;
		btn_first = first;
		btn_second = second;
		btn_third = third;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Event receiver: checks each transfer and stalls at random, once for a long stretch.
	initial begin
		expected_event_t want;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				events_seen++;
				if (pending_events.size() == 0) begin
					$display("%0t ns: unexpected event, expected none, actual key %h",
						$time, m_axis_tdata[OUT_KEY_LSB +: KEY_W]);
					mismatches++;
				end else begin
					want = pending_events.pop_front();
					check_field("is_press", 8'(want.is_press), 8'(m_axis_tuser[0]));
					check_field("event_key", want.key, m_axis_tdata[OUT_KEY_LSB +: KEY_W]);
					check_field("event_modifier", want.mods, m_axis_tdata[OUT_MOD_LSB +: MOD_W]);
					check_field("mouse_send", 8'(want.send), 8'(m_axis_tdata[OUT_SEND_LSB]));
					check_field("mouse_buttons", 8'(want.buttons),
						8'(m_axis_tdata[OUT_BTN_LSB +: BTN_W]));
					check_field("last_event", 8'(want.last), 8'(m_axis_tlast));
				end
				if (events_seen == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	// Stimulus: directed table first, then random phases under different button settings.
	initial begin
		table_row_t rows[$];
		expected_event_t none;
		none = '{1'b0, 8'h00, 8'h00, 1'b0, 3'd0, 1'b0};

		// First press after reset uses the reset button value.
		rows.push_back('{make_report(8, 8'h00, 4, 0, 0, 0, 0, 0), ONE_EVENT,
			'{1'b1, KEY_CODE_FIRST, 8'h00, 1'b1, BTN_FIRST_RST, 1'b1}});
		// Short reports are ignored and leave the held keys alone.
		rows.push_back('{make_report(7, 8'h00, 5, 6, 7, 0, 0, 0), NO_EVENTS, none});
		rows.push_back('{make_report(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			NO_EVENTS, none});
		// Same keys again give nothing.
		rows.push_back('{make_report(8, 8'h00, 4, 0, 0, 0, 0, 0), NO_EVENTS, none});
		// A release clears the buttons and drops the modifier.
		rows.push_back('{make_report(8, 8'h5A, 0, 0, 0, 0, 0, 0), ONE_EVENT,
			'{1'b0, KEY_CODE_FIRST, 8'h00, 1'b1, 3'd0, 1'b1}});
		rows.push_back('{make_report(64, 8'h00, 5, 6, 0, 0, 0, 0), BY_PREDICTOR, none});
		// Left shift suppresses the mouse report; the right-shift report only releases keys.
		rows.push_back('{make_report(8, 8'h02, 4, 5, 6, 7, 0, 0), BY_PREDICTOR, none});
		rows.push_back('{make_report(8, 8'h20, 0, 0, 0, 0, 0, 0), BY_PREDICTOR, none});
		// Reserved codes never cause events.
		rows.push_back('{make_report(8, 8'h00, 1, 2, 3, 0, 3, 1), NO_EVENTS, none});
		rows.push_back('{make_report(63, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA),
			BY_PREDICTOR, none});
		// Every slot changes: a release and a press per slot.
		rows.push_back('{make_report(8, 8'h00, 4, 5, 6, 8'h80, 8'h81, 8'h82),
			BY_PREDICTOR, none});
		rows.push_back('{make_report(8, 8'h00, 0, 0, 0, 0, 0, 0), BY_PREDICTOR, none});
		// Duplicate codes are judged per slot on press and on release.
		rows.push_back('{make_report(8, 8'h00, 4, 4, 5, 5, 6, 8'h7F), BY_PREDICTOR, none});
		rows.push_back('{make_report(8, 8'h22, 0, 0, 0, 0, 0, 0), BY_PREDICTOR, none});
		// Modifier bits other than shift do not block the mouse report.
		rows.push_back('{make_report(8, 8'hDD, 6, 0, 0, 0, 0, 0), BY_PREDICTOR, none});
		// A key that only moves to another slot stays held.
		rows.push_back('{make_report(9, 8'h01, 0, 6, 0, 0, 0, 0), NO_EVENTS, none});
		rows.push_back('{make_report(8, 8'h00, 8'h55, 8'hAA, 0, 0, 0, 0), BY_PREDICTOR, none});
		rows.push_back('{make_report(64, 8'h00, 0, 0, 0, 0, 0, 0), BY_PREDICTOR, none});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_report(rows[i].report, rows[i].kind, rows[i].typed);
		end
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: write_buttons(3'd0, 3'd0, 3'd0);
				1: write_buttons(3'd7, 3'd7, 3'd7);
				default: write_buttons(BTN_W'($urandom_range(0, 7)),
					BTN_W'($urandom_range(0, 7)), BTN_W'($urandom_range(0, 7)));
			endcase
			calm = (phase == 2);
			repeat (RANDOM_PER_PHASE) begin
				send_report(random_report(), BY_PREDICTOR, none);
			end
			drain();
			calm = 1'b0;
		end

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
